// ===== rtl/core/hdr_pkg.sv =====
`timescale 1ns / 1ps

package hdr_pkg;

  localparam int ROUTER_W = 16;
  localparam int TERM_W = 20;
  localparam int PORT_W = 7;
  localparam int VC_W = 4;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 5;
  localparam int RADIX_W = 5;
  localparam int DIMS_W = 3;
  localparam int CONC_W = 5;
  localparam int VCS_W = 5;
  localparam int VC_MAX = 16;

  // quotient bits resolved per pipeline stage
  localparam int STEPS_PER_STG = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIX_K         = 4'd0,
    REG_DIMENSIONS_N    = 4'd1,
    REG_CONCENTRATION_C = 4'd2,
    REG_VC_COUNT        = 4'd3
  } cfg_reg_t;

endpackage

// ===== rtl/core/hyperx_dor_route_compute.sv =====
`timescale 1ns / 1ps

// HyperX dimension-order route computation. Each item (current router, destination
// terminal, injection flag) yields exactly one result: output port, eject flag, vc
// range and a range error when either router id is at or above K^N. A new item is
// taken every cycle while in_stall is low. The result comes from a chain of restoring
// long divisions, terminal by C and then both router ids by K once per dimension,
// resolved five quotient bits per pipeline stage. The router id range check falls
// out of those same divisions. Stalls on the result side back up through the stage
// valids, so empty stages still fill while a result waits.
// Registers are read live and must only be written while no item is in flight.
module hyperx_dor_route_compute #(
  parameter int MAX_RADIX = 16,
  parameter int MAX_DIMS = 4,
  parameter int MAX_CONC = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [hdr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hdr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [hdr_pkg::ROUTER_W-1:0]    in_current_router,
  input  logic [hdr_pkg::TERM_W-1:0]      in_dest_terminal,
  input  logic                            in_injecting,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_no_route,
  output logic [hdr_pkg::PORT_W-1:0]      out_egress,
  output logic                            out_ejecting,
  output logic [hdr_pkg::VC_W-1:0]        out_vc_first,
  output logic [hdr_pkg::VC_W-1:0]        out_vc_last,
  output logic                            out_range_error
);

  localparam int TW = hdr_pkg::TERM_W;
  localparam int P = hdr_pkg::STEPS_PER_STG;
  localparam int KW = $clog2(MAX_RADIX + 1);
  localparam int CW = $clog2(MAX_CONC + 1);
  localparam int NW = $clog2(MAX_DIMS + 1);
  localparam int DIVW = (KW > CW) ? KW : CW;
  localparam int PW_NEED = $clog2(MAX_DIMS * (MAX_RADIX - 1) + MAX_CONC);
  localparam int PWI = (PW_NEED > hdr_pkg::PORT_W) ? PW_NEED : hdr_pkg::PORT_W;
  localparam int NSTG = (TW * (MAX_DIMS + 1)) / P;

  typedef struct packed {
    logic [TW-1:0]   qa;        // terminal, then destination router quotient
    logic [TW-1:0]   qb;        // current router quotient
    logic [DIVW-1:0] ra;
    logic [DIVW-1:0] rb;
    logic [CW-1:0]   term_rem;
    logic            same;
    logic            inj;
    logic            err;
    logic            found;
    logic [PWI-1:0]  acc;       // sum of (k-1) over dimensions passed
    logic [PWI-1:0]  port;
  } pipe_t;

  logic [hdr_pkg::RADIX_W-1:0] radix_r;
  logic [hdr_pkg::DIMS_W-1:0]  dims_r;
  logic [hdr_pkg::CONC_W-1:0]  conc_r;
  logic [hdr_pkg::VCS_W-1:0]   vcs_r;

  logic [KW-1:0]               k_cl;
  logic [NW-1:0]               n_cl;
  logic [CW-1:0]               c_cl;
  logic [hdr_pkg::VCS_W-1:0]   vcs_cl;

  pipe_t                       entry;
  pipe_t                       stg_nxt [NSTG];
  pipe_t                       stg_r [NSTG];
  logic [NSTG-1:0]             v_r;
  logic [NSTG:0]               adv;

  logic                        out_valid_r;
  logic                        no_route_r;
  logic [hdr_pkg::PORT_W-1:0]  port_r;
  logic                        ejecting_r;
  logic [hdr_pkg::VC_W-1:0]    vc_last_r;
  logic                        range_error_r;

  logic                        no_route_nxt;
  logic [PWI-1:0]              port_nxt;
  logic                        ejecting_nxt;
  logic [hdr_pkg::VC_W-1:0]    vc_last_nxt;
  logic                        range_error_nxt;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= hdr_pkg::RADIX_W'(4);
      dims_r  <= hdr_pkg::DIMS_W'(2);
      conc_r  <= hdr_pkg::CONC_W'(1);
      vcs_r   <= hdr_pkg::VCS_W'(4);
    end else if (cfg_valid && cfg_ready) begin
      unique case (hdr_pkg::cfg_reg_t'(cfg_index))
        hdr_pkg::REG_RADIX_K:         radix_r <= cfg_data;
        hdr_pkg::REG_DIMENSIONS_N:    dims_r  <= cfg_data[hdr_pkg::DIMS_W-1:0];
        hdr_pkg::REG_CONCENTRATION_C: conc_r  <= cfg_data;
        hdr_pkg::REG_VC_COUNT:        vcs_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (radix_r < hdr_pkg::RADIX_W'(2)) begin
      k_cl = KW'(2);
    end else if (int'(radix_r) > MAX_RADIX) begin
      k_cl = KW'(MAX_RADIX);
    end else begin
      k_cl = KW'(radix_r);
    end

    if (dims_r == '0) begin
      n_cl = NW'(1);
    end else if (int'(dims_r) > MAX_DIMS) begin
      n_cl = NW'(MAX_DIMS);
    end else begin
      n_cl = NW'(dims_r);
    end

    if (conc_r == '0) begin
      c_cl = CW'(1);
    end else if (int'(conc_r) > MAX_CONC) begin
      c_cl = CW'(MAX_CONC);
    end else begin
      c_cl = CW'(conc_r);
    end

    if (vcs_r == '0) begin
      vcs_cl = hdr_pkg::VCS_W'(1);
    end else if (int'(vcs_r) > hdr_pkg::VC_MAX) begin
      vcs_cl = hdr_pkg::VCS_W'(hdr_pkg::VC_MAX);
    end else begin
      vcs_cl = vcs_r;
    end
  end

  // flow control: a stage moves when it is empty or the one after it moves
  always_comb begin
    adv[NSTG] = !out_valid_r || !out_stall;
    for (int s = NSTG - 1; s >= 0; s--) begin
      adv[s] = !v_r[s] || adv[s+1];
    end
  end

  assign in_stall = !adv[0];

  always_comb begin
    entry = '0;
    entry.qa = in_dest_terminal;
    entry.qb = TW'(in_current_router);
    entry.inj = in_injecting;
  end

  // division pipeline: first the terminal by c, then both router ids by k per dimension
  for (genvar s = 0; s < NSTG; s++) begin : g_stage
    pipe_t src;
    pipe_t step_nxt;

    if (s == 0) begin : g_first
      assign src = entry;
    end else begin : g_rest
      assign src = stg_r[s-1];
    end

    always_comb begin
      pipe_t         w;
      logic [DIVW:0] ta;
      logic [DIVW:0] tb;
      logic [DIVW:0] dv;
      logic [DIVW:0] dd;
      int            g;
      int            ph;
      int            dim;
      w = src;
      ta = '0;
      tb = '0;
      dd = '0;
      for (int p = 0; p < P; p++) begin
        g = s * P + p;
        ph = g / hdr_pkg::TERM_W;
        dim = ph - 1;
        dv = (ph == 0) ? (DIVW+1)'(c_cl) : (DIVW+1)'(k_cl);

        ta = {w.ra, w.qa[TW-1]};
        w.qa = {w.qa[TW-2:0], 1'b0};
        if (ta >= dv) begin
          ta = ta - dv;
          w.qa[0] = 1'b1;
        end
        w.ra = ta[DIVW-1:0];

        if (ph != 0) begin
          tb = {w.rb, w.qb[TW-1]};
          w.qb = {w.qb[TW-2:0], 1'b0};
          if (tb >= dv) begin
            tb = tb - dv;
            w.qb[0] = 1'b1;
          end
          w.rb = tb[DIVW-1:0];
        end

        // end of one full division
        if ((g % hdr_pkg::TERM_W) == hdr_pkg::TERM_W - 1) begin
          if (ph == 0) begin
            w.term_rem = w.ra[CW-1:0];
            w.same = (w.qa == w.qb);
          end else if (dim < int'(n_cl)) begin
            if (!w.found && (w.ra != w.rb)) begin
              // wrapped offset of the destination digit
              if (w.ra >= w.rb) begin
                dd = {1'b0, w.ra} - {1'b0, w.rb};
              end else begin
                dd = {1'b0, w.ra} + (DIVW+1)'(k_cl) - {1'b0, w.rb};
              end
              w.found = 1'b1;
              w.port = w.acc + PWI'(dd) - PWI'(1);
            end
            w.acc = w.acc + PWI'(k_cl) - PWI'(1);
            if (dim == int'(n_cl) - 1) begin
              w.err = (w.qa != '0) || (w.qb != '0);
            end
          end
          w.ra = '0;
          w.rb = '0;
        end
      end
      step_nxt = w;
    end

    assign stg_nxt[s] = step_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_valid;
      end
      for (int s = 1; s < NSTG; s++) begin
        if (adv[s]) begin
          v_r[s] <= v_r[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < NSTG; s++) begin
      if (adv[s]) begin
        stg_r[s] <= stg_nxt[s];
      end
    end
  end

  // result selection
  always_comb begin
    pipe_t fin;
    fin = stg_r[NSTG-1];
    no_route_nxt = fin.inj;
    range_error_nxt = fin.err;
    ejecting_nxt = 1'b0;
    port_nxt = '0;
    vc_last_nxt = hdr_pkg::VC_W'(vcs_cl - hdr_pkg::VCS_W'(1));
    if (fin.inj || fin.err) begin
      port_nxt = '0;
    end else if (fin.same) begin
      ejecting_nxt = 1'b1;
      port_nxt = fin.acc + PWI'(fin.term_rem);
    end else begin
      port_nxt = fin.port;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv[NSTG]) begin
      out_valid_r <= v_r[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[NSTG]) begin
      no_route_r    <= no_route_nxt;
      port_r        <= port_nxt[hdr_pkg::PORT_W-1:0];
      ejecting_r    <= ejecting_nxt;
      vc_last_r     <= vc_last_nxt;
      range_error_r <= range_error_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_no_route    = no_route_r;
  assign out_egress      = port_r;
  assign out_ejecting    = ejecting_r;
  assign out_vc_first    = '0;
  assign out_vc_last     = vc_last_r;
  assign out_range_error = range_error_r;

  // input side only stalls when every stage holds an item and the result is held
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> ((&v_r) && out_valid_r && out_stall))
    else $error("input stalled with room in the pipeline");

  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v_r[0])
    else $error("accepted item not captured in first stage");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_no_route) |-> (!out_ejecting && (out_egress == '0)))
    else $error("injection result carries a port");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ejecting) |-> (!out_range_error && !out_no_route))
    else $error("ejection reported on an invalid or injection item");

endmodule
